// ===== src/epsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// epsgd_pkg
// Shared sizes, opcodes and fixed-point widths of the embedding pair trainer.
// ----------------------------------------------------------------------------
package epsgd_pkg;

  localparam int NUM_NODES = 4096;
  localparam int DIM       = 128;

  localparam int ROW_W  = $clog2(NUM_NODES);
  localparam int ELEM_W = $clog2(DIM);
  localparam int IDX_W  = ELEM_W + 1;
  localparam int ADDR_W = ROW_W + ELEM_W;
  localparam int DEPTH  = NUM_NODES * DIM;

  localparam int VAL_W  = 16;
  localparam int ACC_W  = 24;
  localparam int RATE_W = 16;
  localparam int DOT_W  = 2 * VAL_W + ELEM_W;
  localparam int DIFF_W = 18;
  localparam int G_W    = DIFF_W + RATE_W + 1;
  localparam int PROD_W = G_W + VAL_W;
  localparam int Q_W    = 17;
  localparam int DEN_W  = DOT_W + 1;
  localparam int REM_W  = DEN_W + Q_W - 1;
  localparam int CNT_W  = $clog2(Q_W + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TRAIN = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

endpackage

// ===== src/epsgd_cmd_if.sv =====
// ----------------------------------------------------------------------------
// epsgd_cmd_if
// Command channel: valid/ready plus one input item.
// ----------------------------------------------------------------------------
interface epsgd_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic                              table_sel;
  logic [epsgd_pkg::ROW_W-1:0]       row_id;
  logic [epsgd_pkg::ELEM_W-1:0]      element_index;
  logic signed [epsgd_pkg::VAL_W-1:0] write_value;
  logic [epsgd_pkg::ROW_W-1:0]       vertex_id;
  logic [epsgd_pkg::ROW_W-1:0]       context_id;
  logic                              is_positive;
  logic                              last_of_group;
  logic [epsgd_pkg::RATE_W-1:0]      learning_rate;

  modport source (output valid, opcode, table_sel, row_id, element_index, write_value,
                  vertex_id, context_id, is_positive, last_of_group, learning_rate,
                  input ready);
  modport sink (input valid, opcode, table_sel, row_id, element_index, write_value,
                vertex_id, context_id, is_positive, last_of_group, learning_rate,
                output ready);
endinterface

// ===== src/epsgd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// epsgd_rsp_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface epsgd_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [epsgd_pkg::VAL_W-1:0] read_data;
  logic signed [epsgd_pkg::VAL_W-1:0] score;
  logic                               saturated;

  modport source (output valid, read_data, score, saturated, input ready);
  modport sink (input valid, read_data, score, saturated, output ready);
endinterface

// ===== src/epsgd_div.sv =====
// ----------------------------------------------------------------------------
// epsgd_div
// Softsign quotient: round((mag << 15) / (2^24 + mag)), one bit per cycle.
// ----------------------------------------------------------------------------
module epsgd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [epsgd_pkg::DOT_W-1:0]   mag,
  output logic                          done,
  output logic [epsgd_pkg::VAL_W-2:0]   quot
);

  logic [epsgd_pkg::REM_W-1:0] rem;
  logic [epsgd_pkg::REM_W-1:0] dsh;
  logic [epsgd_pkg::Q_W-1:0]   q;
  logic [epsgd_pkg::CNT_W-1:0] cnt;
  logic                        busy;
  logic [epsgd_pkg::DEN_W-1:0] den;
  logic                        ge;

  assign den  = epsgd_pkg::DEN_W'(mag) + (epsgd_pkg::DEN_W'(1) << 24);
  assign ge   = rem >= dsh;
  assign quot = (q > epsgd_pkg::Q_W'(32767)) ? 15'h7fff : q[epsgd_pkg::VAL_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= epsgd_pkg::CNT_W'(epsgd_pkg::Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == epsgd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (epsgd_pkg::REM_W'(mag) << 15) + epsgd_pkg::REM_W'(den >> 1);
      dsh <= epsgd_pkg::REM_W'(den) << (epsgd_pkg::Q_W - 1);
      q   <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[epsgd_pkg::Q_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

// ===== src/embedding_pair_sgd_update.sv =====
// ----------------------------------------------------------------------------
// embedding_pair_sgd_update
// Vertex/context embedding tables with softsign negative-sampling updates.
// ----------------------------------------------------------------------------
// Write, no-op, ignored train: straight to S_FINISH and the result; read: via S_RD.
// Train: bound by one table read port per table: a dot pass over DIM elements,
//   a softsign divide, a gradient step, then one read-modify-write pass over DIM
//   elements (only that pass for a last item with out-of-range context). One item at a time.
// Reset: group state and the error accumulator (valid bits) clear at once;
//   table contents are undefined until written.
module embedding_pair_sgd_update (
  input  logic       clk,
  input  logic       rst,
  epsgd_cmd_if.sink  cmd,
  epsgd_rsp_if.source rsp
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD     = 7'b0000010,
    S_DOT    = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_GCALC  = 7'b0010000,
    S_UPD    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic signed [epsgd_pkg::VAL_W-1:0] vmem [epsgd_pkg::DEPTH];
  logic signed [epsgd_pkg::VAL_W-1:0] cmem [epsgd_pkg::DEPTH];
  logic signed [epsgd_pkg::ACC_W-1:0] amem [epsgd_pkg::DIM];
  logic [epsgd_pkg::DIM-1:0]          acc_valid;

  logic [epsgd_pkg::ADDR_W-1:0] v_raddr, c_raddr, v_waddr, c_waddr;
  logic                         v_we, c_we;
  logic signed [epsgd_pkg::VAL_W-1:0] v_wdata, c_wdata;
  logic signed [epsgd_pkg::VAL_W-1:0] vdat, cdat;
  logic signed [epsgd_pkg::ACC_W-1:0] adat;
  logic                               adat_ok;
  logic [epsgd_pkg::ELEM_W-1:0]       a_raddr;

  logic accept;
  logic [epsgd_pkg::ADDR_W-1:0] cmd_addr;
  logic cmd_in_range;

  logic [epsgd_pkg::ROW_W-1:0] group_vertex, cur_v, cur_c;
  logic                        group_open;
  logic                        tsel_q, pos_q, last_q, ctx_en, train_go;
  logic [epsgd_pkg::RATE_W-1:0] alpha_q;

  logic [epsgd_pkg::IDX_W-1:0]  idx;
  logic                         issue;
  logic                         p1, p2;
  logic [epsgd_pkg::ELEM_W-1:0] idx1, idx2;

  logic signed [2*epsgd_pkg::VAL_W-1:0] prod;
  logic signed [epsgd_pkg::DOT_W-1:0]   fdot;
  logic [epsgd_pkg::DOT_W-1:0]          mag;
  logic                                 div_start, div_done;
  logic [epsgd_pkg::VAL_W-2:0]          quot;

  logic signed [epsgd_pkg::VAL_W-1:0]  score_r, rd_r;
  logic signed [epsgd_pkg::DIFF_W-1:0] diff;
  logic signed [epsgd_pkg::G_W-1:0]    g;
  logic                                clip;

  logic signed [epsgd_pkg::PROD_W-1:0] pc, pv, rc, rv;
  logic signed [epsgd_pkg::VAL_W-1:0]  c2, v2;
  logic signed [epsgd_pkg::ACC_W-1:0]  a2;
  logic signed [epsgd_pkg::PROD_W:0]   acc_sum, c_sum;
  logic signed [epsgd_pkg::ACC_W-1:0]  acc_new, acc_eff;
  logic signed [epsgd_pkg::ACC_W+1:0]  v_sum;
  logic signed [epsgd_pkg::VAL_W-1:0]  c_new, v_new;
  logic                                c_clip, v_clip;

  assign accept       = cmd.valid && cmd.ready;
  assign cmd.ready    = (state == S_IDLE);
  assign cmd_addr     = {cmd.row_id, cmd.element_index};
  assign cmd_in_range = (32'(cmd.row_id) < epsgd_pkg::NUM_NODES) &&
                        (32'(cmd.element_index) < epsgd_pkg::DIM);

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    vdat <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    cdat <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD && p2 && ctx_en) begin
      amem[idx2] <= acc_new;
    end
    adat <= amem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      adat_ok   <= 1'b0;
    end else begin
      adat_ok <= acc_valid[a_raddr];
      if (state == S_UPD && p2) begin
        if (last_q) begin
          acc_valid[idx2] <= 1'b0;
        end else if (ctx_en) begin
          acc_valid[idx2] <= 1'b1;
        end
      end
    end
  end

  // ---- addresses ----
  assign issue   = (state == S_DOT || state == S_UPD) && (idx < epsgd_pkg::IDX_W'(epsgd_pkg::DIM));
  assign a_raddr = idx[epsgd_pkg::ELEM_W-1:0];

  always_comb begin
    if (state == S_IDLE) begin
      v_raddr = cmd_addr;
      c_raddr = cmd_addr;
    end else begin
      v_raddr = {cur_v, idx[epsgd_pkg::ELEM_W-1:0]};
      c_raddr = {cur_c, idx[epsgd_pkg::ELEM_W-1:0]};
    end
  end

  always_comb begin
    v_we    = 1'b0;
    c_we    = 1'b0;
    v_waddr = {cur_v, idx2};
    c_waddr = {cur_c, idx2};
    v_wdata = v_new;
    c_wdata = c_new;
    if (state == S_IDLE) begin
      v_waddr = cmd_addr;
      c_waddr = cmd_addr;
      v_wdata = cmd.write_value;
      c_wdata = cmd.write_value;
      if (accept && epsgd_pkg::opcode_t'(cmd.opcode) == epsgd_pkg::OP_WRITE && cmd_in_range) begin
        v_we = !cmd.table_sel;
        c_we = cmd.table_sel;
      end
    end else if (state == S_UPD && p2) begin
      v_we = last_q;
      c_we = ctx_en;
    end
  end

  // ---- update datapath ----
  assign rc      = (pc + (epsgd_pkg::PROD_W'(1) <<< 30)) >>> 31;
  assign rv      = (pv + (epsgd_pkg::PROD_W'(1) <<< 30)) >>> 31;
  assign acc_sum = (epsgd_pkg::PROD_W+1)'(a2) + (epsgd_pkg::PROD_W+1)'(rc);
  assign c_sum   = (epsgd_pkg::PROD_W+1)'(c2) + (epsgd_pkg::PROD_W+1)'(rv);

  always_comb begin
    if (acc_sum > (epsgd_pkg::PROD_W+1)'(8388607)) begin
      acc_new = 24'sh7fffff;
    end else if (acc_sum < -(epsgd_pkg::PROD_W+1)'(8388608)) begin
      acc_new = -24'sh800000;
    end else begin
      acc_new = acc_sum[epsgd_pkg::ACC_W-1:0];
    end
    acc_eff = ctx_en ? acc_new : a2;
    v_sum   = (epsgd_pkg::ACC_W+2)'(v2) + (epsgd_pkg::ACC_W+2)'(acc_eff);
    c_clip  = 1'b1;
    if (c_sum > (epsgd_pkg::PROD_W+1)'(32767)) begin
      c_new = 16'sh7fff;
    end else if (c_sum < -(epsgd_pkg::PROD_W+1)'(32768)) begin
      c_new = -16'sh8000;
    end else begin
      c_new  = c_sum[epsgd_pkg::VAL_W-1:0];
      c_clip = 1'b0;
    end
    v_clip = 1'b1;
    if (v_sum > (epsgd_pkg::ACC_W+2)'(32767)) begin
      v_new = 16'sh7fff;
    end else if (v_sum < -(epsgd_pkg::ACC_W+2)'(32768)) begin
      v_new = -16'sh8000;
    end else begin
      v_new  = v_sum[epsgd_pkg::VAL_W-1:0];
      v_clip = 1'b0;
    end
  end

  // ---- softsign ----
  assign mag       = fdot[epsgd_pkg::DOT_W-1] ? epsgd_pkg::DOT_W'(-fdot) : epsgd_pkg::DOT_W'(fdot);
  assign div_start = (state == S_DOT) && !issue && !p1 && !p2;
  assign diff      = (pos_q ? 18'sd32768 : 18'sd0) - epsgd_pkg::DIFF_W'(score_r);

  epsgd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .done  (div_done),
    .quot  (quot)
  );

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      group_open   <= 1'b0;
      group_vertex <= '0;
      p1           <= 1'b0;
      p2           <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end
      p1 <= issue;
      p2 <= p1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            score_r <= '0;
            rd_r    <= '0;
            clip    <= 1'b0;
            tsel_q  <= cmd.table_sel;
            pos_q   <= cmd.is_positive;
            last_q  <= cmd.last_of_group;
            alpha_q <= cmd.learning_rate;
            cur_c   <= cmd.context_id;
            idx     <= '0;
            fdot    <= '0;
            train_go <= 1'b0;
            ctx_en  <= 1'b0;
            state   <= S_FINISH;
            case (epsgd_pkg::opcode_t'(cmd.opcode))
              epsgd_pkg::OP_READ: begin
                if (cmd_in_range) begin
                  state <= S_RD;
                end
              end
              epsgd_pkg::OP_TRAIN: begin
                if (group_open || 32'(cmd.vertex_id) < epsgd_pkg::NUM_NODES) begin
                  train_go <= 1'b1;
                  cur_v    <= group_open ? group_vertex : cmd.vertex_id;
                  if (!group_open) begin
                    group_vertex <= cmd.vertex_id;
                  end
                  group_open <= !cmd.last_of_group;
                  if (32'(cmd.context_id) < epsgd_pkg::NUM_NODES) begin
                    ctx_en <= 1'b1;
                    state  <= S_DOT;
                  end else if (cmd.last_of_group) begin
                    state <= S_UPD;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          rd_r  <= tsel_q ? cdat : vdat;
          state <= S_FINISH;
        end
        S_DOT: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (p1) begin
            prod <= vdat * cdat;
          end
          if (p2) begin
            fdot <= fdot + epsgd_pkg::DOT_W'(prod);
          end
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            score_r <= fdot[epsgd_pkg::DOT_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
            state   <= S_GCALC;
          end
        end
        S_GCALC: begin
          g     <= diff * $signed({1'b0, alpha_q});
          idx   <= '0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (issue) begin
            idx  <= idx + 1'b1;
            idx1 <= idx[epsgd_pkg::ELEM_W-1:0];
          end
          if (p1) begin
            pc   <= g * cdat;
            pv   <= g * vdat;
            c2   <= cdat;
            v2   <= vdat;
            a2   <= adat_ok ? adat : '0;
            idx2 <= idx1;
          end
          if (p2) begin
            clip <= clip | (ctx_en & c_clip) | (last_q & v_clip);
          end
          if (!issue && !p1 && !p2) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.read_data <= rd_r;
            rsp.score     <= score_r;
            rsp.saturated <= clip;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks ----
  a_div_to_g: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> state == S_GCALC)
    else $error("divide done did not advance to gradient step");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && $past(state) == S_UPD && last_q) |-> acc_valid == '0)
    else $error("vertex error not cleared at group end");

  a_write_when: assert property (@(posedge clk) disable iff (rst)
    (v_we || c_we) |-> (state == S_IDLE || (state == S_UPD && p2)))
    else $error("table write outside write or update");

  a_group_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && train_go && last_q) |-> !group_open)
    else $error("group still open after last item");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for embedding_pair_sgd_update: fills one vertex row and two
// context rows, then runs directed and random write/read/train transfers and compares
// each result against a directed expected value or an in-bench fixed-point trainer model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    epsgd_pkg::opcode_t op;
    logic              tsel;
    logic [11:0]       row;
    logic [6:0]        elem;
    logic signed [15:0] wval;
    logic [11:0]       vid;
    logic [11:0]       cid;
    logic              pos;
    logic              last;
    logic [15:0]       rate;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] rd;
    logic signed [15:0] score;
    logic               sat;
  } rsp_t;

  typedef struct packed {
    cmd_t c;
    logic chk;
    rsp_t e;
  } dir_t;

  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 20000;
  localparam int N_RAND      = 100;

  logic clk, rst;
  epsgd_cmd_if cmd_if ();
  epsgd_rsp_if rsp_if ();

  embedding_pair_sgd_update u_dut (.clk(clk), .rst(rst), .cmd(cmd_if), .rsp(rsp_if));

  shortint vtab [int];
  shortint ctab [int];
  int      err_acc [epsgd_pkg::DIM];
  logic [11:0] grp_vertex;
  bit      grp_open;
  bit      written [int];
  int      written_keys [$];
  rsp_t    expected_q [$];
  int      fails;
  int      src_idle, snk_idle;
  bit      hold_req;
  int      hold_cnt;
  int      quiet_cycles;

  int vpool [1] = '{3};
  int cpool [2] = '{0, 4095};

  dir_t dir_tab [] = '{
    '{'{epsgd_pkg::OP_WRITE, 1'b0, 12'd4094, 7'd127, 16'sh7fff, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_WRITE, 1'b0, 12'd4094, 7'd0, 16'sh8000, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_WRITE, 1'b1, 12'd4094, 7'd0, 16'sh8000, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_WRITE, 1'b1, 12'd10, 7'd127, 16'sh7fff, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b0, 12'd4094, 7'd127, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sh7fff, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b0, 12'd4094, 7'd0, 16'shffff, 12'hfff, 12'hfff, 1'b1, 1'b1,
        16'hffff},
      1'b1, '{16'sh8000, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b1, 12'd4094, 7'd0, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sh8000, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b1, 12'd10, 7'd127, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sh7fff, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_NOP, 1'b1, 12'hfff, 7'h7f, 16'shffff, 12'hfff, 12'hfff, 1'b1, 1'b1,
        16'hffff},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_NOP, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd3, 12'd0, 1'b1, 1'b0, 16'd0},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd4095, 12'd4095, 1'b0, 1'b0,
        16'hffff},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd0, 12'd0, 1'b1, 1'b1, 16'hffff},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd3, 12'd4095, 1'b1, 1'b1, 16'hffff},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd3, 12'd4095, 1'b0, 1'b1, 16'hffff},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd3, 12'd4095, 1'b1, 1'b0, 16'h8000},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_TRAIN, 1'b0, 12'd0, 7'd0, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b1, 16'd1},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b1, 12'd4095, 7'd5, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b0, '{16'sd0, 16'sd0, 1'b0}},
    '{'{epsgd_pkg::OP_READ, 1'b0, 12'd3, 7'd127, 16'sh0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0},
      1'b0, '{16'sd0, 16'sd0, 1'b0}}
  };

  function automatic shortint sat16(longint x, inout bit clip);
    if (x > 32767) begin
      clip = 1;
      return 16'sh7fff;
    end
    if (x < -32768) begin
      clip = 1;
      return 16'sh8000;
    end
    return shortint'(x);
  endfunction

  function automatic rsp_t train_model(cmd_t c);
    rsp_t r;
    longint f, g, mag, q, cv, vv, delta;
    int a, vb, cb;
    bit clip;
    r = '0;
    clip = 0;
    a = int'({c.row, c.elem});
    case (c.op)
      epsgd_pkg::OP_WRITE: begin
        if (c.tsel) ctab[a] = c.wval;
        else vtab[a] = c.wval;
      end
      epsgd_pkg::OP_READ: r.rd = c.tsel ? ctab[a] : vtab[a];
      epsgd_pkg::OP_TRAIN: begin
        if (!grp_open) begin
          grp_vertex = c.vid;
          grp_open = 1;
        end
        vb = int'(grp_vertex) * epsgd_pkg::DIM;
        cb = int'(c.cid) * epsgd_pkg::DIM;
        f = 0;
        for (int d = 0; d < epsgd_pkg::DIM; d++)
          f += longint'(vtab[vb + d]) * longint'(ctab[cb + d]);
        mag = f < 0 ? -f : f;
        q = ((mag << 15) + (((64'd1 << 24) + mag) >> 1)) / ((64'd1 << 24) + mag);
        if (q > 32767) q = 32767;
        if (f < 0) q = -q;
        r.score = q[15:0];
        g = ((c.pos ? 64'sd32768 : 64'sd0) - q) * longint'(c.rate);
        for (int d = 0; d < epsgd_pkg::DIM; d++) begin
          cv = ctab[cb + d];
          vv = vtab[vb + d];
          delta = longint'(err_acc[d]) + ((g * cv + (64'sd1 <<< 30)) >>> 31);
          err_acc[d] = delta > 8388607 ? 8388607 : (delta < -8388608 ? -8388608 : int'(delta));
          ctab[cb + d] = sat16(cv + ((g * vv + (64'sd1 <<< 30)) >>> 31), clip);
        end
        if (c.last) begin
          for (int d = 0; d < epsgd_pkg::DIM; d++) begin
            vtab[vb + d] = sat16(longint'(vtab[vb + d]) + err_acc[d], clip);
            err_acc[d] = 0;
          end
          grp_open = 0;
        end
      end
      default: ;
    endcase
    r.sat = clip;
    return r;
  endfunction

  task automatic send(cmd_t c, bit chk = 0, rsp_t e = '0);
    rsp_t p;
    int key;
    while ($urandom_range(99) < src_idle) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= c.op;
    cmd_if.table_sel     <= c.tsel;
    cmd_if.row_id        <= c.row;
    cmd_if.element_index <= c.elem;
    cmd_if.write_value   <= c.wval;
    cmd_if.vertex_id     <= c.vid;
    cmd_if.context_id    <= c.cid;
    cmd_if.is_positive   <= c.pos;
    cmd_if.last_of_group <= c.last;
    cmd_if.learning_rate <= c.rate;
    do @(posedge clk); while (!cmd_if.ready);
    key = int'({c.tsel, c.row, c.elem});
    if (c.op == epsgd_pkg::OP_WRITE && !written.exists(key)) begin
      written[key] = 1;
      written_keys.push_back(key);
    end
    p = train_model(c);
    expected_q.push_back(chk ? e : p);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_val();
    return ($urandom_range(99) < 80) ? 16'($signed($urandom_range(4095)) - 2048)
                                     : 16'($urandom);
  endfunction

  function automatic cmd_t rand_cmd(ref int grp_left);
    cmd_t c;
    int k, pick;
    c = '{op: epsgd_pkg::OP_NOP, default: '0};
    c.row  = 12'($urandom);
    c.elem = 7'($urandom);
    c.wval = 16'($urandom);
    c.vid  = 12'($urandom);
    c.cid  = 12'($urandom);
    c.pos  = 1'($urandom);
    c.last = 1'($urandom);
    c.rate = 16'($urandom);
    c.tsel = 1'($urandom);
    pick = (grp_left > 0) ? 0 : $urandom_range(99);
    if (pick < 60) begin
      c.op = epsgd_pkg::OP_TRAIN;
      if (grp_left == 0) begin
        grp_left = $urandom_range(1, 5);
        c.vid = 12'(vpool[$urandom_range($size(vpool) - 1)]);
      end
      c.cid = 12'(cpool[$urandom_range($size(cpool) - 1)]);
      k = $urandom_range(9);
      if (k == 0) c.rate = 16'd0;
      else if (k == 1) c.rate = 16'hffff;
      c.last = (grp_left == 1);
      grp_left--;
    end else if (pick < 78) begin
      c.op = epsgd_pkg::OP_WRITE;
      c.wval = rand_val();
      if ($urandom_range(1))
        c.row = c.tsel ? 12'(cpool[$urandom_range($size(cpool) - 1)])
                       : 12'(vpool[$urandom_range($size(vpool) - 1)]);
    end else if (pick < 95) begin
      c.op = epsgd_pkg::OP_READ;
      k = written_keys[$urandom_range(written_keys.size() - 1)];
      {c.tsel, c.row, c.elem} = k[19:0];
    end
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.opcode <= '0;
    cmd_if.table_sel <= '0;
    cmd_if.row_id <= '0;
    cmd_if.element_index <= '0;
    cmd_if.write_value <= '0;
    cmd_if.vertex_id <= '0;
    cmd_if.context_id <= '0;
    cmd_if.is_positive <= '0;
    cmd_if.last_of_group <= '0;
    cmd_if.learning_rate <= '0;
    rsp_if.ready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rsp_t e;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result rd=%0d score=%0d sat=%0b", $time,
                   rsp_if.read_data, rsp_if.score, rsp_if.saturated);
        end else begin
          e = expected_q.pop_front();
          if (rsp_if.read_data !== e.rd || rsp_if.score !== e.score ||
              rsp_if.saturated !== e.sat) begin
            fails++;
            $display("%0t: mismatch expected rd=%0d score=%0d sat=%0b actual rd=%0d score=%0d sat=%0b",
                     $time, e.rd, e.score, e.sat, rsp_if.read_data, rsp_if.score,
                     rsp_if.saturated);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  initial begin
    cmd_t c;
    int grp_left;
    fails = 0;
    grp_open = 0;
    grp_vertex = '0;
    foreach (err_acc[d]) err_acc[d] = 0;
    src_idle = 26;
    snk_idle = 74;
    grp_left = 0;
    @(negedge rst);
    @(posedge clk);
    c = '{op: epsgd_pkg::OP_WRITE, default: '0};
    foreach (vpool[i]) for (int d = 0; d < epsgd_pkg::DIM; d++) begin
      c.tsel = 0;
      c.row = 12'(vpool[i]);
      c.elem = 7'(d);
      c.wval = (vpool[i] == 4095) ? 16'sh8000 : rand_val();
      send(c);
    end
    foreach (cpool[i]) for (int d = 0; d < epsgd_pkg::DIM; d++) begin
      c.tsel = 1;
      c.row = 12'(cpool[i]);
      c.elem = 7'(d);
      c.wval = (cpool[i] == 4095) ? 16'sh7fff : rand_val();
      send(c);
    end
    foreach (dir_tab[i]) send(dir_tab[i].c, dir_tab[i].chk, dir_tab[i].e);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 3) begin
        src_idle = 74;
        snk_idle = 26;
      end
      if (n == 2 * N_RAND / 3) begin
        drain();
        @(posedge clk);
        src_idle = 0;
        snk_idle = 0;
        hold_req = 1;
        for (int k = 0; k < 20; k++) begin
          c = '{op: epsgd_pkg::OP_WRITE, default: '0};
          c.tsel = 1'($urandom);
          c.row = 12'($urandom);
          c.elem = 7'($urandom);
          c.wval = 16'($urandom);
          send(c);
        end
      end
      c = rand_cmd(grp_left);
      send(c);
    end
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
